>>> hdl/lisl_pkg.sv
// Shared types for the longest increasing subsequence length unit.
// Used by lisl_cell, lisl_tally and the top level; depends on nothing.
package lisl_pkg;

  // Control part of the token that walks down the cell chain with each request.
  typedef struct packed {
    logic vld;       // token carries a request, not a bubble
    logic last;      // request closes the sequence
    logic placed;    // some cell has already taken the value
    logic appended;  // the value went into an empty cell (length grows)
  } tok_ctrl_t;

endpackage

>>> hdl/lisl_cell.sv
// One cell of the tail chain: holds one tail value and its occupancy bit.
// Uses lisl_pkg::tok_ctrl_t; instantiated in a row by the top level.
module lisl_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          strict_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  lisl_pkg::tok_ctrl_t           ctrl_i,
  output logic signed [VALUE_WIDTH-1:0] key_o,
  output lisl_pkg::tok_ctrl_t           ctrl_o
);

  logic signed [VALUE_WIDTH-1:0] tail_q, tail_d;
  logic signed [VALUE_WIDTH-1:0] key_q;
  logic                          used_q, used_d;
  lisl_pkg::tok_ctrl_t           ctrl_q, ctrl_d;
  logic                          hit;
  logic                          take;

  // The occupied cells form a prefix and the hit test is monotonic along it,
  // so the first cell that can take the value is the one that takes it.
  always_comb begin
    hit    = used_q && (strict_i ? (tail_q >= key_i) : (tail_q > key_i));
    take   = ctrl_i.vld && !ctrl_i.placed && (hit || !used_q);
    ctrl_d = ctrl_i;
    tail_d = tail_q;
    used_d = used_q;
    if (take) begin
      ctrl_d.placed = 1'b1;
      ctrl_d.appended = !used_q;
      tail_d = key_i;
      used_d = 1'b1;
    end
    if (ctrl_i.vld && ctrl_i.last) begin
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      ctrl_q <= '0;
    end else if (adv_i) begin
      used_q <= used_d;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tail_q <= tail_d;
      key_q  <= key_i;
    end
  end

  assign key_o  = key_q;
  assign ctrl_o = ctrl_q;

`ifndef SYNTHESIS
  // A token that was already placed upstream must leave this cell untouched.
  // An empty cell's tail is not used by the hit test, so only its occupancy counts.
  a_placed_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && ctrl_i.vld && ctrl_i.placed && !ctrl_i.last)
      |=> ($stable(used_q) && (!used_q || $stable(tail_q))))
    else $error("placed token modified a cell");
`endif

endmodule

>>> hdl/lisl_tally.sv
// Chain end: keeps the subsequence length and sticky overflow flag and
// holds the result register. Uses lisl_pkg::tok_ctrl_t.
module lisl_tally #(
  parameter int unsigned MAX_LENGTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  lisl_pkg::tok_ctrl_t                  ctrl_i,
  output logic                                 vld_o,
  output logic [$clog2(MAX_LENGTH+1)-1:0]      len_o,
  output logic                                 ovf_o,
  output logic                                 last_o
);

  localparam int unsigned LenW = $clog2(MAX_LENGTH + 1);

  logic [LenW-1:0] cnt_q, cnt_d, cnt_next;
  logic            ovf_q, ovf_d, ovf_next;
  logic            vld_q;
  logic [LenW-1:0] len_q;
  logic            ovf_out_q;
  logic            last_q;

  always_comb begin
    cnt_next = cnt_q + LenW'(ctrl_i.appended);
    ovf_next = ovf_q | !ctrl_i.placed;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    if (ctrl_i.vld) begin
      cnt_d = ctrl_i.last ? '0 : cnt_next;
      ovf_d = ctrl_i.last ? 1'b0 : ovf_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      vld_q <= 1'b0;
    end else if (adv_i) begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      vld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && ctrl_i.vld) begin
      len_q     <= cnt_next;
      ovf_out_q <= ovf_next;
      last_q    <= ctrl_i.last;
    end
  end

  assign vld_o  = vld_q;
  assign len_o  = len_q;
  assign ovf_o  = ovf_out_q;
  assign last_o = last_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LenW'(MAX_LENGTH))
    else $error("length count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == LenW'(MAX_LENGTH)))
    else $error("overflow flag set while store not full");

  a_result_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && ovf_out_q) |-> (len_q == LenW'(MAX_LENGTH)))
    else $error("overflow reported with length below capacity");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && ctrl_i.vld && ctrl_i.last) |=> (cnt_q == '0 && !ovf_q))
    else $error("sequence end did not clear the count");
`endif

endmodule

>>> hdl/longest_increasing_subsequence_length_unit.sv
// Top level of the longest increasing subsequence length unit.
// Depends on lisl_pkg, lisl_cell and lisl_tally.
//
// Usage:
//   Values stream in on the s_axis channel, one signed value per request, with
//   tlast marking the final value of a sequence. For every request one result
//   leaves on the m_axis channel: the longest subsequence length so far, the
//   sticky overflow flag and an echo of tlast.
//   A row of MAX_LENGTH cells holds the tails, one per cell. Each request
//   travels down the row one cell per cycle; the first cell whose tail is not
//   less than the value (greater than it in non-decreasing mode) takes it, or
//   the first empty cell appends it. If every cell is full and none takes the
//   value, it is dropped and the overflow flag rises at the chain end.
//   A request passes the MAX_LENGTH cells, then the result register; a new
//   request is taken in every cycle unless the receiver stalls, since each
//   trails its predecessor by exactly one cell and so sees its finished state.
//   A request with tlast empties each cell as it passes and clears the length
//   and overflow at the chain end after its own result is formed.
//   When the receiver stalls, the whole row and the input side stall with it
//   (s_axis_tready_o follows the output register being free or taken).
//   Reset empties all cells, clears length and overflow and sets strict mode;
//   no clearing pass is needed. strict_mode is written over the cfg channel,
//   which is always ready, and should change only while the unit is idle.
module longest_increasing_subsequence_length_unit #(
  parameter int unsigned MAX_LENGTH  = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Configuration write channel: data bit 0 is strict_mode.
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic                                        cfg_data_i,
  // Input stream. tdata: value (VALUE_WIDTH bits), zero padding above.
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]            s_axis_tdata_i,
  input  logic                                        s_axis_tlast_i,
  // Result stream. tdata: length ($clog2(MAX_LENGTH+1) bits), overflow,
  // zero padding above.
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  output logic [(($clog2(MAX_LENGTH+1)+8)/8)*8-1:0]   m_axis_tdata_o,
  output logic                                        m_axis_tlast_o
);

  localparam int unsigned LenW  = $clog2(MAX_LENGTH + 1);
  localparam int unsigned OutW  = ((LenW + 8) / 8) * 8;

  logic                          strict_q;
  logic                          adv;
  logic signed [VALUE_WIDTH-1:0] key_w  [MAX_LENGTH+1];
  lisl_pkg::tok_ctrl_t           ctrl_w [MAX_LENGTH+1];
  logic                          res_vld;
  logic [LenW-1:0]               res_len;
  logic                          res_ovf;
  logic                          res_last;

  // Mode register; the write channel never back-pressures.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b1;
    end else if (cfg_valid_i) begin
      strict_q <= cfg_data_i;
    end
  end

  // The row moves whenever the result register is empty or being emptied.
  assign adv             = !res_vld || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Token entering the first cell; a bubble when no request is offered.
  assign key_w[0]  = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign ctrl_w[0] = '{vld: s_axis_tvalid_i, last: s_axis_tlast_i,
                       placed: 1'b0, appended: 1'b0};

  for (genvar gi = 0; gi < MAX_LENGTH; gi++) begin : g_cell
    lisl_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .strict_i(strict_q),
      .key_i   (key_w[gi]),
      .ctrl_i  (ctrl_w[gi]),
      .key_o   (key_w[gi+1]),
      .ctrl_o  (ctrl_w[gi+1])
    );
  end

  // The key leaving the last cell is not needed any further; only the
  // control part decides length and overflow.
  lisl_tally #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_tally (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .ctrl_i(ctrl_w[MAX_LENGTH]),
    .vld_o (res_vld),
    .len_o (res_len),
    .ovf_o (res_ovf),
    .last_o(res_last)
  );

  assign m_axis_tvalid_o = res_vld;
  assign m_axis_tdata_o  = OutW'({res_ovf, res_len});
  assign m_axis_tlast_o  = res_last;

`ifndef SYNTHESIS
  // A request offered while the result register is full and stalled is not
  // taken; the row and the input side move together.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result stalled");

  // The result register changes only when the row advances.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> ($stable(res_len) && $stable(res_ovf)))
    else $error("stalled result changed");
`endif

endmodule
